// ===== src/ntfsdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfsdr_pkg
// Shared types and constants of the data-run list decoder.
// ----------------------------------------------------------------------------
package ntfsdr_pkg;

  localparam int MAX_FIELD_BYTES_DEF = 8;

  localparam int BPC_W      = 22;
  localparam int VOL_W      = 48;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [BPC_W-1:0] BPC_RESET = 22'd4096;

  localparam logic [CFG_ADDR_W-1:0] CFG_BPC = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VOL = 1'd1;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_SPARSE = 2'd1,
    KIND_END    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_OFFSET = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] lcn;
    logic [63:0] clusters;
  } run_res_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] lcn;
    logic [63:0] clusters;
    logic [53:0] c_lo;
    logic [31:0] c_hi;
    logic [53:0] l_lo;
    logic [31:0] l_hi;
  } run_prod_t;

endpackage
`default_nettype wire

// ===== src/ntfsdr_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfsdr_decoder
// Header and field byte parser; keeps the running cluster number and
// registers one run result per finished run, end marker or bad header.
// ----------------------------------------------------------------------------
module ntfsdr_decoder import ntfsdr_pkg::*; #(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire logic [7:0] run_byte,
  input  wire logic     list_start,
  output logic          res_valid,
  input  wire logic     res_ready,
  output run_res_t      res
);

  localparam int          ACC_W  = 8 * MAX_FIELD_BYTES;
  localparam logic [3:0]  MAX_SZ = 4'(MAX_FIELD_BYTES);

  phase_t             phase_r, phase_nxt;
  logic [3:0]         len_size_r, len_size_nxt;
  logic [3:0]         off_size_r, off_size_nxt;
  logic [3:0]         left_r, left_nxt;
  logic [ACC_W-1:0]   len_acc_r, len_acc_nxt;
  logic [ACC_W-1:0]   off_acc_r, off_acc_nxt;
  logic [63:0]        lcn_r, lcn_nxt;
  logic               res_valid_r, res_valid_nxt;
  run_res_t           res_r, res_nxt;
  phase_t             ph;
  logic [63:0]        base_lcn;
  logic [2:0]         idx;
  logic               accept;

  function automatic logic [63:0] sext_field(input logic [63:0] v, input logic [3:0] sz);
    logic        sgn;
    logic [63:0] r;
    sgn = 1'b0;
    r   = v;
    for (int k = 0; k < 8; k++) begin
      if (sz == 4'(k + 1)) sgn = v[8*k+7];
    end
    for (int k = 0; k < 8; k++) begin
      if (4'(k) >= sz) r[8*k +: 8] = {8{sgn}};
    end
    return r;
  endfunction

  assign byte_ready = !res_valid_r || res_ready;
  assign accept     = byte_valid && byte_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    phase_nxt     = phase_r;
    len_size_nxt  = len_size_r;
    off_size_nxt  = off_size_r;
    left_nxt      = left_r;
    len_acc_nxt   = len_acc_r;
    off_acc_nxt   = off_acc_r;
    lcn_nxt       = lcn_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    ph            = phase_r;
    base_lcn      = lcn_r;
    idx           = 3'd0;
    if (accept) begin
      if (list_start) begin
        ph       = PH_HEADER;
        base_lcn = '0;
      end
      lcn_nxt = base_lcn;
      case (ph)
        PH_LENGTH: begin
          idx = 3'(len_size_r - left_r);
          for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
            if (idx == 3'(k)) len_acc_nxt[8*k +: 8] = run_byte;
          end
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            if (off_size_r != 4'd0) begin
              phase_nxt = PH_OFFSET;
              left_nxt  = off_size_r;
            end else begin
              phase_nxt        = PH_HEADER;
              left_nxt         = 4'd0;
              res_valid_nxt    = 1'b1;
              res_nxt.kind     = KIND_SPARSE;
              res_nxt.lcn      = base_lcn;
              res_nxt.clusters = 64'(len_acc_nxt);
            end
          end
        end
        PH_OFFSET: begin
          idx = 3'(off_size_r - left_r);
          for (int k = 0; k < MAX_FIELD_BYTES; k++) begin
            if (idx == 3'(k)) off_acc_nxt[8*k +: 8] = run_byte;
          end
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            phase_nxt        = PH_HEADER;
            left_nxt         = 4'd0;
            lcn_nxt          = base_lcn + sext_field(64'(off_acc_nxt), off_size_r);
            res_valid_nxt    = 1'b1;
            res_nxt.kind     = KIND_RUN;
            res_nxt.lcn      = lcn_nxt;
            res_nxt.clusters = 64'(len_acc_r);
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (run_byte == 8'd0) begin
            res_valid_nxt    = 1'b1;
            res_nxt.kind     = KIND_END;
            res_nxt.lcn      = '0;
            res_nxt.clusters = '0;
          end else begin
            len_size_nxt = run_byte[3:0];
            off_size_nxt = run_byte[7:4];
            len_acc_nxt  = '0;
            off_acc_nxt  = '0;
            left_nxt     = 4'd0;
            if (len_size_nxt > MAX_SZ || off_size_nxt > MAX_SZ) begin
              len_size_nxt     = 4'd0;
              off_size_nxt     = 4'd0;
              res_valid_nxt    = 1'b1;
              res_nxt.kind     = KIND_BAD;
              res_nxt.lcn      = '0;
              res_nxt.clusters = '0;
            end else if (len_size_nxt != 4'd0) begin
              phase_nxt = PH_LENGTH;
              left_nxt  = len_size_nxt;
            end else begin
              phase_nxt = PH_OFFSET;
              left_nxt  = off_size_nxt;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      len_size_r  <= 4'd0;
      off_size_r  <= 4'd0;
      left_r      <= 4'd0;
      len_acc_r   <= '0;
      off_acc_r   <= '0;
      lcn_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_size_r  <= len_size_nxt;
      off_size_r  <= off_size_nxt;
      left_r      <= left_nxt;
      len_acc_r   <= len_acc_nxt;
      off_acc_r   <= off_acc_nxt;
      lcn_r       <= lcn_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== src/ntfsdr_mult.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfsdr_mult
// Partial products of cluster count and cluster number by cluster size,
// split into 32-bit halves.
// ----------------------------------------------------------------------------
module ntfsdr_mult import ntfsdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [BPC_W-1:0] bpc,
  input  wire logic             res_valid,
  output logic                  res_ready,
  input  wire run_res_t         res,
  output logic                  prod_valid,
  input  wire logic             prod_ready,
  output run_prod_t             prod
);

  logic        valid_r;
  run_prod_t   prod_r, prod_nxt;
  logic [53:0] c_hi_full;
  logic [53:0] l_hi_full;

  assign res_ready  = !valid_r || prod_ready;
  assign prod_valid = valid_r;
  assign prod       = prod_r;

  always_comb begin
    c_hi_full         = res.clusters[63:32] * bpc;
    l_hi_full         = res.lcn[63:32] * bpc;
    prod_nxt.kind     = res.kind;
    prod_nxt.lcn      = res.lcn;
    prod_nxt.clusters = res.clusters;
    prod_nxt.c_lo     = res.clusters[31:0] * bpc;
    prod_nxt.c_hi     = c_hi_full[31:0];
    prod_nxt.l_lo     = res.lcn[31:0] * bpc;
    prod_nxt.l_hi     = l_hi_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/ntfsdr_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfsdr_sum
// Final sums of the partial products and the volume offset; output register.
// ----------------------------------------------------------------------------
module ntfsdr_sum import ntfsdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VOL_W-1:0] vol,
  input  wire logic             prod_valid,
  output logic                  prod_ready,
  input  wire run_prod_t        prod,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            kind,
  output logic [255:0]          data
);

  logic         valid_r;
  logic [1:0]   kind_r;
  logic [255:0] data_r;
  logic [63:0]  bytes_nxt;
  logic [63:0]  addr_nxt;

  assign prod_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign kind       = kind_r;
  assign data       = data_r;

  always_comb begin
    bytes_nxt = 64'(prod.c_lo) + {prod.c_hi, 32'd0};
    addr_nxt  = 64'(prod.l_lo) + {prod.l_hi, 32'd0} + 64'(vol);
    if (prod.kind != KIND_RUN) addr_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prod_ready) begin
      valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      kind_r <= prod.kind;
      data_r <= {addr_nxt, bytes_nxt, prod.clusters, prod.lcn};
    end
  end

endmodule
`default_nettype wire

// ===== src/ntfs_data_run_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder
// Decoder for the data-run list of a non-resident NTFS attribute.
// ----------------------------------------------------------------------------
// Bytes of the run list enter on the in_ stream, one item per cycle; in_tuser
// set marks the first byte of a new list and clears the running cluster
// number. One result item leaves on the out_ stream per finished run, per
// zero header (end of list) and per header with an oversized field.
// Throughput is one byte per cycle while in_tready is high. A finished run's
// result passes the parser result register, the partial-product register
// (four 32x22 multipliers), then the output register that adds the halves
// and the volume start. The three stages are elastic: while out_tready is
// low, bytes are still taken until all three stages hold a result, then
// in_tready drops. cfg_ writes set the cluster size (index 0) and volume
// start (index 1); the user must make them only while the block is idle,
// which the block does not enforce. Reset clears the parser to expect a
// header, the running cluster number to zero, the cluster size to 4096
// and the volume start to zero; no result is pending after reset.
// ----------------------------------------------------------------------------
module ntfs_data_run_decoder import ntfsdr_pkg::*; #(
  parameter int MAX_FIELD_BYTES = MAX_FIELD_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // run_byte
  input  wire logic                  in_tuser,   // list_start
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [255:0]               out_tdata,  // run_lcn, run_clusters, run_bytes,
                                                 // disk_byte_address
  output logic [1:0]                 out_tuser,  // kind
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [BPC_W-1:0] bpc_r;
  logic [VOL_W-1:0] vol_r;
  logic             res_valid, res_ready;
  run_res_t         res;
  logic             prod_valid, prod_ready;
  run_prod_t        prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r <= BPC_RESET;
      vol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BPC: bpc_r <= cfg_wdata[BPC_W-1:0];
        CFG_VOL: vol_r <= cfg_wdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  ntfsdr_decoder #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .run_byte   (in_tdata),
    .list_start (in_tuser),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  ntfsdr_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .bpc        (bpc_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  ntfsdr_sum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .vol        (vol_r),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .kind       (out_tuser),
    .data       (out_tdata)
  );

endmodule
`default_nettype wire

// ===== src/ntfsdr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntfsdr_checker
// Port-level checks of the data-run list decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ntfsdr_checker import ntfsdr_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [255:0] out_tdata,
  input wire logic [1:0]   out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_BAD) |-> out_tdata == '0)
    else $error("end or bad-header item carries data");

  a_sparse_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SPARSE |-> out_tdata[255:192] == 64'd0)
    else $error("sparse run carries a disk address");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind ntfs_data_run_decoder ntfsdr_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/run_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_list_checker
// Watches the byte, result and register ports of the data-run decoder, keeps
// its own decode of every accepted byte and compares each result item, field
// by field, with the oldest decoded run still waiting.
// ----------------------------------------------------------------------------
module run_list_checker import ntfsdr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [7:0]            in_tdata,   // run_byte
  input  wire logic                  in_tuser,   // list_start
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [255:0]          out_tdata,  // run_lcn, run_clusters, run_bytes,
                                                 // disk_byte_address
  input  wire logic [1:0]            out_tuser,  // kind
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         failures,
  output int                         pending
);

  typedef struct packed {
    kind_t       kind;
    logic [63:0] lcn;
    logic [63:0] clusters;
    logic [63:0] nbytes;
    logic [63:0] address;
  } decoded_run_t;

  logic [BPC_W-1:0] cluster_size;
  logic [VOL_W-1:0] volume_base;

  phase_t      parse_phase;
  logic [3:0]  len_size;
  logic [3:0]  off_size;
  logic [3:0]  left;
  logic [63:0] len_acc;
  logic [63:0] off_acc;
  logic [63:0] lcn;

  decoded_run_t expected_runs[$];

  task automatic report(input string msg);
    if (failures < 40) $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  function automatic void close_run(output decoded_run_t res);
    logic [63:0] off;
    int          off_bits;
    res = '0;
    parse_phase = PH_HEADER;
    left = '0;
    res.clusters = len_acc;
    res.nbytes = len_acc * 64'(cluster_size);
    if (off_size == 4'd0) begin
      res.kind = KIND_SPARSE;
      res.lcn = lcn;
    end else begin
      off = off_acc;
      off_bits = 8 * int'(off_size);
      if (off_size < 4'd8 && off[off_bits-1]) off |= ~64'd0 << off_bits;
      lcn = lcn + off;
      res.kind = KIND_RUN;
      res.lcn = lcn;
      res.address = lcn * 64'(cluster_size) + 64'(volume_base);
    end
  endfunction

  function automatic bit step_run_parser(input logic [7:0] rb, input logic start,
                                         output decoded_run_t res);
    res = '0;
    if (start) begin
      lcn = '0;
      parse_phase = PH_HEADER;
    end
    if (parse_phase == PH_LENGTH) begin
      len_acc |= 64'(rb) << (8 * (int'(len_size) - int'(left)));
      left = left - 4'd1;
      if (left != 4'd0) return 1'b0;
      if (off_size != 4'd0) begin
        parse_phase = PH_OFFSET;
        left = off_size;
        return 1'b0;
      end
      close_run(res);
      return 1'b1;
    end
    if (parse_phase == PH_OFFSET) begin
      off_acc |= 64'(rb) << (8 * (int'(off_size) - int'(left)));
      left = left - 4'd1;
      if (left != 4'd0) return 1'b0;
      close_run(res);
      return 1'b1;
    end
    parse_phase = PH_HEADER;
    if (rb == 8'd0) begin
      res.kind = KIND_END;
      return 1'b1;
    end
    len_size = rb[3:0];
    off_size = rb[7:4];
    len_acc = '0;
    off_acc = '0;
    left = '0;
    if (len_size > MAX_FIELD_BYTES_DEF || off_size > MAX_FIELD_BYTES_DEF) begin
      len_size = '0;
      off_size = '0;
      res.kind = KIND_BAD;
      return 1'b1;
    end
    if (len_size != 4'd0) begin
      parse_phase = PH_LENGTH;
      left = len_size;
      return 1'b0;
    end
    if (off_size != 4'd0) begin
      parse_phase = PH_OFFSET;
      left = off_size;
      return 1'b0;
    end
    close_run(res);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    decoded_run_t fresh;
    decoded_run_t got;
    decoded_run_t want;
    if (!rst_n) begin
      cluster_size = BPC_RESET;
      volume_base = '0;
      parse_phase = PH_HEADER;
      len_size = '0;
      off_size = '0;
      left = '0;
      len_acc = '0;
      off_acc = '0;
      lcn = '0;
      expected_runs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BPC: cluster_size = cfg_wdata[BPC_W-1:0];
          CFG_VOL: volume_base = cfg_wdata[VOL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (step_run_parser(in_tdata, in_tuser, fresh)) expected_runs.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.lcn = out_tdata[63:0];
        got.clusters = out_tdata[127:64];
        got.nbytes = out_tdata[191:128];
        got.address = out_tdata[255:192];
        if (expected_runs.size() == 0) begin
          report($sformatf("result item of kind %0d with none expected", out_tuser));
        end else begin
          want = expected_runs.pop_front();
          check_field("kind", {62'd0, got.kind}, {62'd0, want.kind});
          check_field("run_lcn", got.lcn, want.lcn);
          check_field("run_clusters", got.clusters, want.clusters);
          check_field("run_bytes", got.nbytes, want.nbytes);
          check_field("disk_byte_address", got.address, want.address);
        end
      end
    end
    pending <= expected_runs.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte stimulus for the data-run list decoder.
// Sends a short directed list, then random run lists with random field sizes
// and contents, cut lists and stray bytes, under several cluster sizes and
// volume offsets; both sides idle at random and the checker judges results.
// ----------------------------------------------------------------------------
module testbench;
  import ntfsdr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // run_byte
  logic                  in_tuser;   // list_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [255:0]          out_tdata;  // run_lcn, run_clusters, run_bytes,
                                     // disk_byte_address
  logic [1:0]            out_tuser;  // kind
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int failures;
  int pending;
  int items_sent;
  int cycle_count;
  bit calm_in;
  bit calm_out;

  logic [8:0] directed_items[$];

  ntfs_data_run_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  run_list_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: stall, then raise ready and hold it until out_tvalid is seen high
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic push_item(input logic [7:0] rb, input logic start);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= rb;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold the byte stream until every decoded run has left
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [BPC_W-1:0] bpc, input logic [VOL_W-1:0] vol);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_BPC;
    cfg_wdata <= {26'($urandom), bpc};
    @(posedge clk);
    cfg_addr <= CFG_VOL;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_field_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 8;
    if (r == 2) return $urandom_range(5, 7);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_run_list();
    int  runs;
    int  ls;
    int  os;
    int  cut;
    logic first;
    runs = $urandom_range(1, 6);
    first = 1'b1;
    for (int r = 0; r < runs; r++) begin
      ls = pick_field_size();
      os = pick_field_size();
      if (ls == 0 && os == 0) ls = 1;
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, ls + os - 1) : ls + os;
      push_item({4'(os), 4'(ls)}, first);
      first = 1'b0;
      repeat (cut) push_item(8'($urandom_range(0, 255)), 1'b0);
      if (cut != ls + os) return;
    end
    if ($urandom_range(0, 4) != 0) push_item(8'd0, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: push_item({4'($urandom_range(9, 15)), 4'($urandom_range(0, 15))}, 1'b0);
        1: push_item({4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))}, 1'b0);
        default: push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      endcase
    end
  endtask

  initial begin
    int               target;
    logic [BPC_W-1:0] bpc;
    logic [VOL_W-1:0] vol;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_BPC;
    cfg_wdata = '0;
    items_sent = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    directed_items = '{9'h100, 9'h121, 9'h0FF, 9'h034, 9'h012, 9'h011, 9'h001, 9'h080,
                       9'h001, 9'h005, 9'h010, 9'h002, 9'h009, 9'h090, 9'h022, 9'h010,
                       9'h100, 9'h018, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
                       9'h0FF, 9'h0FF, 9'h07F, 9'h000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        foreach (directed_items[i]) push_item(directed_items[i][7:0], directed_items[i][8]);
      end else begin
        drain();
        vol = {16'($urandom), 32'($urandom)};
        case (p)
          1: begin bpc = 22'd2; vol = '0; end
          2: begin bpc = 22'd2097152; vol = '1; end
          3: bpc = '1;
          4: bpc = '0;
          5: bpc = 22'd512;
          default: bpc = BPC_W'(2 * $urandom_range(1, 1048576));
        endcase
        set_geometry(bpc, vol);
      end
      target = items_sent + 235;
      while (items_sent < target) begin
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_run_list();
        if ($urandom_range(0, 30) == 0) drain();
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ntfs_data_run_decoder.f =====
src/ntfsdr_pkg.sv
src/ntfsdr_decoder.sv
src/ntfsdr_mult.sv
src/ntfsdr_sum.sv
src/ntfs_data_run_decoder.sv
src/ntfsdr_checker.sv
tb/sv/run_list_checker.sv
tb/sv/testbench.sv
